### sv/htfd_pkg.sv
`default_nettype none
package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [7:0] SCALE_TEMP  = 8'd175;
  localparam logic [7:0] SCALE_HUMID = 8'd100;
  localparam logic [8:0] TEMP_OFFSET = 9'd45;

  localparam logic QTY_TEMP  = 1'b0;
  localparam logic QTY_HUMID = 1'b1;

  typedef enum logic [2:0] {
    POS_HIGH = 3'b001,
    POS_LOW  = 3'b010,
    POS_CRC  = 3'b100
  } pos_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/humidity_temp_frame_decoder_unit.sv
`default_nettype none
// Channel  Direction  Payload                                   Flow
// in_      input      data_byte[7:0], quantity                  in_valid / in_stall
// out_     output     value[8:0] signed, crc_error, which,      out_valid / out_stall
//                     raw_word[15:0]
// One byte is taken per cycle unless stalled; the CRC byte stage registers the result.
// The low byte stage registers the scaled product and the CRC byte stage divides it.
// Reset is synchronous and returns the frame position to the high byte.
// A stalled result holds only bytes that end a frame; data bytes still flow.
module humidity_temp_frame_decoder_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [7:0]        in_data_byte,
  input  wire               in_quantity,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [8:0] out_value,
  output logic              out_crc_error,
  output logic              out_which,
  output logic [15:0]       out_raw_word
);

  logic            in_vld_r;
  logic [7:0]      in_byte_r;
  logic            in_qty_r;

  htfd_pkg::pos_t  pos_r, pos_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [7:0]      high_r;
  logic [7:0]      low_r;
  logic            qty_r;
  logic [23:0]     prod_r;

  logic            out_vld_r;
  logic signed [8:0] out_value_r;
  logic            out_err_r;
  logic            out_which_r;
  logic [15:0]     out_raw_r;

  logic            stage_move;
  logic            frame_end;
  logic            out_take;
  logic [7:0]      scale;
  logic [24:0]     quot_sum;
  logic [8:0]      quot;
  logic [24:0]     back_mult;
  logic            rem_nz;
  logic [9:0]      temp_val;
  logic signed [8:0] conv_val;
  logic            crc_bad;

  assign frame_end  = in_vld_r && (pos_r == htfd_pkg::POS_CRC);
  assign out_take   = out_vld_r && !out_stall;
  assign stage_move = in_vld_r && !(frame_end && out_vld_r && out_stall);
  assign in_stall   = in_vld_r && !stage_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_qty_r  <= in_quantity;
    end
  end

  assign scale = (qty_r == htfd_pkg::QTY_HUMID) ? htfd_pkg::SCALE_HUMID
                                                : htfd_pkg::SCALE_TEMP;

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    case (pos_r)
      htfd_pkg::POS_LOW: begin
        pos_nxt = htfd_pkg::POS_CRC;
        crc_nxt = htfd_pkg::crc8_byte(crc_r, in_byte_r);
      end
      htfd_pkg::POS_CRC: begin
        pos_nxt = htfd_pkg::POS_HIGH;
        crc_nxt = htfd_pkg::CRC_INIT;
      end
      default: begin
        pos_nxt = htfd_pkg::POS_LOW;
        crc_nxt = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, in_byte_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= htfd_pkg::POS_HIGH;
      crc_r  <= htfd_pkg::CRC_INIT;
      high_r <= 8'd0;
      low_r  <= 8'd0;
      qty_r  <= htfd_pkg::QTY_TEMP;
    end else if (stage_move) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      if (pos_r == htfd_pkg::POS_LOW) begin
        low_r <= in_byte_r;
      end else if (pos_r != htfd_pkg::POS_CRC) begin
        high_r <= in_byte_r;
        qty_r  <= in_qty_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move && (pos_r == htfd_pkg::POS_LOW)) begin
      prod_r <= {8'd0, high_r, in_byte_r} * {16'd0, scale};
    end
  end

  // Division by 65535 uses x / (2^16 - 1) = (x + (x >> 16) + 1) >> 16 for x below 2^24.
  assign quot_sum  = {1'b0, prod_r} + {9'd0, prod_r[23:16]} + 25'd1;
  assign quot      = quot_sum[24:16];
  assign back_mult = {quot, 16'd0} - {16'd0, quot};
  assign rem_nz    = (back_mult[23:0] != prod_r);

  // A negative temperature truncates toward zero, so a nonzero remainder rounds up.
  assign temp_val = {1'b0, quot} - {1'b0, htfd_pkg::TEMP_OFFSET}
                  + {9'd0, (quot < htfd_pkg::TEMP_OFFSET) && rem_nz};

  assign conv_val = (qty_r == htfd_pkg::QTY_HUMID) ? $signed(quot) : $signed(temp_val[8:0]);
  assign crc_bad  = (crc_r != in_byte_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_move && frame_end) begin
      out_vld_r <= 1'b1;
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
    if (stage_move && frame_end) begin
      out_value_r <= crc_bad ? 9'sd0 : conv_val;
      out_err_r   <= crc_bad;
      out_which_r <= qty_r;
      out_raw_r   <= {high_r, low_r};
    end
  end

  assign out_valid     = out_vld_r;
  assign out_value     = out_value_r;
  assign out_crc_error = out_err_r;
  assign out_which     = out_which_r;
  assign out_raw_word  = out_raw_r;

endmodule
`default_nettype wire
